[design/assert_macros.svh]
// assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lpmd_pkg.sv]
// types and codes of the length-prefixed message deframer
package lpmd_pkg;

  // result kind codes
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_TRUNC   = 2'd2;

  localparam int unsigned HDR_BYTES = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] msg_type;
    logic [31:0] msg_size;
    logic [7:0]  data_byte;
    logic        last_of_message;
    logic        truncated;
  } res_t;

endpackage

[design/lpmd_if.sv]
// stream channels of the deframer: byte input and result output
interface lpmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface lpmd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] msg_type;
  logic [31:0] msg_size;
  logic [7:0]  data_byte;
  logic        last_of_message;
  logic        truncated;

  modport source (output valid, output kind, output msg_type, output msg_size,
                  output data_byte, output last_of_message, output truncated,
                  input ready);
  modport sink   (input valid, input kind, input msg_type, input msg_size,
                  input data_byte, input last_of_message, input truncated,
                  output ready);
endinterface

[design/length_prefixed_message_deframer_core.sv]
// top level of the length-prefixed message deframer
// Takes one received byte per beat and splits the stream into messages of a
// 4-byte big-endian type, a 4-byte big-endian size and that many payload
// bytes. A header result comes out with the eighth header byte, then one
// result per payload byte; a byte marked end_of_buffer restarts framing and
// flags truncation if a message was open. The block takes one byte every
// cycle: a byte is held in the input register, is parsed, and its result
// (if any) is loaded into the output register. The only limit on rate is the
// output register: while a result waits there unaccepted, the input register
// holds its byte, and in_ch.ready follows out_ch.ready combinationally
// through that one stage.
`include "assert_macros.svh"

module length_prefixed_message_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  lpmd_in_if.sink     in_ch,
  lpmd_out_if.source  out_ch
);

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_eob_r;

  // output register
  logic           out_v_r;
  lpmd_pkg::res_t out_res_r;

  logic           out_free;
  logic           step;
  logic           res_vld;
  lpmd_pkg::res_t res;

  // parse the held byte once the output register can take its result
  assign out_free    = !out_v_r || out_ch.ready;
  assign step        = in_v_r && out_free;
  assign in_ch.ready = !in_v_r || step;

  lpmd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .eob     (in_eob_r),
    .res_vld (res_vld),
    .res     (res)
  );

  // input beat capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
      in_eob_r  <= in_ch.end_of_buffer;
    end
  end

  // result register: loaded when a parsed byte yields a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step && res_vld) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.kind            = out_res_r.kind;
  assign out_ch.msg_type        = out_res_r.msg_type;
  assign out_ch.msg_size        = out_res_r.msg_size;
  assign out_ch.data_byte       = out_res_r.data_byte;
  assign out_ch.last_of_message = out_res_r.last_of_message;
  assign out_ch.truncated       = out_res_r.truncated;

  // a byte blocked by a waiting result must stay put
  `AST_NEXT(a_in_held, in_v_r && !out_free, in_v_r && $stable(in_byte_r), "input byte lost")
  // a waiting result is neither dropped nor overwritten
  `AST_NEXT(a_out_held, out_v_r && !out_ch.ready, out_v_r && $stable(out_res_r), "result overwritten")
  // a truncation notice inside a header always carries the truncated flag
  `AST_IMPL(a_trunc_flag, out_v_r && out_res_r.kind == lpmd_pkg::KIND_TRUNC,
            out_res_r.truncated, "truncation notice without flag")

endmodule

[design/lpmd_parser.sv]
// framing state and per-byte parse logic of the deframer
`include "assert_macros.svh"

module lpmd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  input  logic               eob,
  output logic               res_vld,
  output lpmd_pkg::res_t     res
);

  logic [2:0]  hdr_cnt_r,  hdr_cnt_nxt;
  logic        in_pay_r,   in_pay_nxt;
  logic [31:0] type_r,     type_nxt;
  logic [31:0] size_r,     size_nxt;
  logic [31:0] remain_r,   remain_nxt;

  always_comb begin
    logic fin;
    logic [31:0] tw;
    logic [31:0] sw;
    fin         = (remain_r[31:1] == 31'd0);
    tw          = (hdr_cnt_r == 3'd0) ? 32'd0 : type_r;
    sw          = (hdr_cnt_r == 3'd0) ? 32'd0 : size_r;
    hdr_cnt_nxt = hdr_cnt_r;
    in_pay_nxt  = in_pay_r;
    type_nxt    = type_r;
    size_nxt    = size_r;
    remain_nxt  = remain_r;
    res_vld     = 1'b0;
    res.kind            = lpmd_pkg::KIND_HEADER;
    res.data_byte       = 8'd0;
    res.last_of_message = 1'b0;
    res.truncated       = 1'b0;

    if (in_pay_r) begin
      res_vld             = 1'b1;
      res.kind            = lpmd_pkg::KIND_PAYLOAD;
      res.data_byte       = rx_byte;
      res.last_of_message = fin;
      res.truncated       = eob && !fin;
      if (fin) begin
        remain_nxt = 32'd0;
        in_pay_nxt = 1'b0;
      end else begin
        remain_nxt = remain_r - 32'd1;
      end
      if (eob) begin
        hdr_cnt_nxt = 3'd0;
        in_pay_nxt  = 1'b0;
        remain_nxt  = 32'd0;
      end
    end else begin
      // first four bytes build the type, the next four the size
      if (!hdr_cnt_r[2]) begin
        tw = {tw[23:0], rx_byte};
      end else begin
        sw = {sw[23:0], rx_byte};
      end
      type_nxt = tw;
      size_nxt = sw;
      if (hdr_cnt_r == 3'(lpmd_pkg::HDR_BYTES - 1)) begin
        hdr_cnt_nxt         = 3'd0;
        res_vld             = 1'b1;
        res.kind            = lpmd_pkg::KIND_HEADER;
        res.last_of_message = (sw == 32'd0);
        if (sw != 32'd0) begin
          in_pay_nxt = 1'b1;
          remain_nxt = sw;
        end
        if (eob) begin
          res.truncated = (sw != 32'd0);
          in_pay_nxt    = 1'b0;
          remain_nxt    = 32'd0;
        end
      end else begin
        hdr_cnt_nxt = hdr_cnt_r + 3'd1;
        if (eob) begin
          res_vld       = 1'b1;
          res.kind      = lpmd_pkg::KIND_TRUNC;
          res.truncated = 1'b1;
          hdr_cnt_nxt   = 3'd0;
          in_pay_nxt    = 1'b0;
          remain_nxt    = 32'd0;
        end
      end
    end
    res.msg_type = type_nxt;
    res.msg_size = size_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r <= 3'd0;
      in_pay_r  <= 1'b0;
      type_r    <= 32'd0;
      size_r    <= 32'd0;
      remain_r  <= 32'd0;
    end else if (step) begin
      hdr_cnt_r <= hdr_cnt_nxt;
      in_pay_r  <= in_pay_nxt;
      type_r    <= type_nxt;
      size_r    <= size_nxt;
      remain_r  <= remain_nxt;
    end
  end

  `AST_IMPL(a_hdr_idle_in_pay, in_pay_r, hdr_cnt_r == 3'd0, "header count moved during payload")
  `AST_IMPL(a_pay_has_remain, in_pay_r, remain_r != 32'd0, "payload state with nothing left")
  `AST_NEXT(a_eob_restarts, step && eob, !in_pay_r && hdr_cnt_r == 3'd0, "framing not restarted")

endmodule

[dv/tb_top.sv]
// testbench of the length-prefixed message deframer: directed frames, random streams, backpressure
`timescale 1ns / 100ps

module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lpmd_in_if  in_ch ();
  lpmd_out_if out_ch ();

  length_prefixed_message_deframer_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // parser state mirrored from the input beats
  logic [2:0]  hdr_cnt = '0;
  logic        in_pay = 1'b0;
  logic [31:0] type_acc = '0;
  logic [31:0] size_acc = '0;
  logic [31:0] pay_left = '0;

  lpmd_pkg::res_t expected_q[$];
  int unsigned fail_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned stall_left = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.end_of_buffer = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic void restart_frame();
    hdr_cnt = '0;
    in_pay = 1'b0;
    pay_left = '0;
  endfunction

  // advances the mirrored parser by one byte; returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] b, input logic eob,
                                    output lpmd_pkg::res_t r);
    bit   got;
    logic fin;
    r = '0;
    got = 1'b0;
    if (in_pay) begin
      fin = (pay_left <= 32'd1);
      r.kind = lpmd_pkg::KIND_PAYLOAD;
      r.data_byte = b;
      r.last_of_message = fin;
      r.truncated = eob && !fin;
      got = 1'b1;
      if (fin) begin
        pay_left = '0;
        in_pay = 1'b0;
      end else begin
        pay_left = pay_left - 32'd1;
      end
      if (eob) restart_frame();
    end else begin
      if (hdr_cnt == 3'd0) begin
        type_acc = '0;
        size_acc = '0;
      end
      if (hdr_cnt < 3'd4) type_acc = {type_acc[23:0], b};
      else size_acc = {size_acc[23:0], b};
      if (hdr_cnt == 3'd7) begin
        hdr_cnt = '0;
        r.kind = lpmd_pkg::KIND_HEADER;
        r.last_of_message = (size_acc == '0);
        got = 1'b1;
        if (size_acc != '0) begin
          in_pay = 1'b1;
          pay_left = size_acc;
        end
        if (eob) begin
          r.truncated = (size_acc != '0);
          restart_frame();
        end
      end else begin
        hdr_cnt = hdr_cnt + 3'd1;
        if (eob) begin
          r.kind = lpmd_pkg::KIND_TRUNC;
          r.truncated = 1'b1;
          got = 1'b1;
          restart_frame();
        end
      end
    end
    r.msg_type = type_acc;
    r.msg_size = size_acc;
    return got;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (seen !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, seen);
      fail_cnt++;
    end
  endfunction

  // predict on each accepted byte, then check each accepted result
  always @(posedge clk) begin
    lpmd_pkg::res_t r;
    lpmd_pkg::res_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (parse_byte(in_ch.rx_byte, in_ch.end_of_buffer, r)) expected_q = {expected_q, r};
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: kind %0d", out_ch.kind);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", want.kind, out_ch.kind);
        check_field("msg_type", want.msg_type, out_ch.msg_type);
        check_field("msg_size", want.msg_size, out_ch.msg_size);
        check_field("data_byte", want.data_byte, out_ch.data_byte);
        check_field("last_of_message", want.last_of_message, out_ch.last_of_message);
        check_field("truncated", want.truncated, out_ch.truncated);
      end
    end
  end

  // receiver: random idling, or a forced hold-off while stall_left runs down
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.end_of_buffer <= eob;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // header then payload; cut >= 0 puts end_of_buffer on that byte and stops there
  task automatic send_message(input logic [31:0] mtype, input logic [31:0] msize,
                              input int cut);
    logic [63:0] hdr;
    logic [7:0]  b;
    int          total;
    hdr = {mtype, msize};
    total = (cut >= 0) ? cut + 1 : 8 + int'(msize);
    for (int i = 0; i < total; i++) begin
      if (i < 8) b = hdr[63 - 8*i -: 8];
      else b = 8'($urandom);
      send_byte(b, i == cut);
    end
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    // bytes that give no result may still sit in the pipeline
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed_frames();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    // zero-size message with an all-ones type: last on the header
    send_message(32'hFFFF_FFFF, 32'h0, -1);
    // largest size, buffer ends on the first payload byte
    send_message(32'h0000_0000, 32'hFFFF_FFFF, 8);
    // buffer ends inside the type word
    send_message(32'hA5C3_0F12, 32'h0, 2);
    // buffer ends on the very first header byte
    send_message(32'h5A00_0000, 32'h0, 0);
    wait_drain();
  endtask

  task automatic test_random_stream(input int unsigned snd_pct, input int unsigned rcv_pct,
                                    input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    logic [31:0] msize;
    int          cut;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 10) begin
        // noise burst, always closed by end_of_buffer to resync
        len = $urandom_range(1, 12);
        for (int i = 0; i < int'(len); i++)
          send_byte(8'($urandom), (i == int'(len) - 1) || ($urandom_range(99) < 10));
      end else begin
        pick = $urandom_range(99);
        if (pick < 15) msize = 32'd0;
        else if (pick < 75) msize = $urandom_range(1, 8);
        else if (pick < 92) msize = $urandom_range(9, 40);
        else msize = $urandom | 32'h100;
        pick = $urandom_range(99);
        if (msize > 32'd40) cut = $urandom_range(0, 20);
        else if (pick < 12) cut = $urandom_range(0, 7 + int'(msize));
        else if (pick < 30) cut = 7 + int'(msize);
        else cut = -1;
        send_message($urandom, msize, cut);
      end
    end
    wait_drain();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_stall();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    stall_left = 200;
    for (int i = 0; i < 4; i++) send_message($urandom, 32'd4, -1);
    wait_drain();
  endtask

  // sender stops mid-message until every result is out, then finishes it
  task automatic test_sender_pause();
    logic [63:0] hdr;
    snd_idle_pct = 0;
    rcv_idle_pct = 30;
    hdr = {32'($urandom), 32'd6};
    for (int i = 0; i < 8; i++) send_byte(hdr[63 - 8*i -: 8], 1'b0);
    wait_drain();
    for (int i = 0; i < 6; i++) send_byte(8'($urandom), 1'b0);
    wait_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_random_stream(10, 87, 170);
    test_random_stream(87, 10, 170);
    test_random_stream(0, 0, 170);
    test_output_stall();
    test_sender_pause();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $error("timeout with %0d results outstanding", expected_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

[length_prefixed_message_deframer_core.f]
+incdir+design
design/lpmd_pkg.sv
design/lpmd_if.sv
design/lpmd_parser.sv
design/length_prefixed_message_deframer_core.sv
dv/tb_top.sv
